/* hw/rtl/prh_pkg.sv */
// shared types and constants of the palette remap block
package prh_pkg;

  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned NUM_COLORS = 2 ** COLOR_W;
  localparam int unsigned COUNT_BITS = 24;

  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_REMAP = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_COUNT = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/prh_if.sv */
// valid/ready channel interfaces for input and result beats
interface prh_in_if import prh_pkg::*; ();
  logic   valid;
  logic   ready;
  op_e    operation;
  color_t color_index;
  color_t map_value;
  logic   end_of_block;

  modport source (output valid, output operation, output color_index,
                  output map_value, output end_of_block, input ready);
  modport sink   (input valid, input operation, input color_index,
                  input map_value, input end_of_block, output ready);
endinterface

interface prh_out_if import prh_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_e  result_kind;
  color_t mapped_pixel;
  count_t count_value;
  logic   end_last;

  modport source (output valid, output result_kind, output mapped_pixel,
                  output count_value, output end_last, input ready);
  modport sink   (input valid, input result_kind, input mapped_pixel,
                  input count_value, input end_last, output ready);
endinterface

/* hw/rtl/palette_remap_with_histogram.sv */
// top level of the palette remap block with per-color histogram
// Each input beat is one operation: remap a pixel through the 256-entry color
// map (bumping that color's saturating 24-bit occurrence counter), load one
// map entry, read one counter, or clear every counter at once. Remap and read
// give one result beat; load and clear give none. The block works on one beat
// at a time: in the idle state the beat is accepted and both memories (color
// map and counters) are read at the same address, and then in the execute
// state the counter is written back and the result register is loaded. For
// a remap or a read the execute state waits while the result register still
// holds a beat the sink has not taken, so a stalled sink holds the beat back;
// a load or a clear never waits.
// A new input beat is still taken while a finished result waits in the output
// register. Counters come up cleared after reset through per-color valid
// bits, with no clearing pass; a map entry must be loaded before a pixel of
// that color is remapped.
module palette_remap_with_histogram import prh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  prh_in_if.sink    in_i,
  prh_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: idle / execute
  prh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, valid bits and the result register
  prh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (in_i.operation),
    .color_index_i  (in_i.color_index),
    .map_value_i    (in_i.map_value),
    .end_of_block_i (in_i.end_of_block),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_kind_o  (out_o.result_kind),
    .mapped_pixel_o (out_o.mapped_pixel),
    .count_value_o  (out_o.count_value),
    .end_last_o     (out_o.end_last)
  );

endmodule

/* hw/rtl/prh_ctrl.sv */
// controller state machine of the palette remap block
module prh_ctrl import prh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts_i.has_result || sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.execute = !sts_i.has_result || sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/prh_datapath.sv */
// color map, counter memory, valid bits and result register
module prh_datapath import prh_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  output sts_t   sts_o,
  input  op_e    operation_i,
  input  color_t color_index_i,
  input  color_t map_value_i,
  input  logic   end_of_block_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output kind_e  result_kind_o,
  output color_t mapped_pixel_o,
  output count_t count_value_o,
  output logic   end_last_o
);

  color_t color_map_mem [NUM_COLORS];
  count_t color_counts_mem [NUM_COLORS];
  logic [NUM_COLORS-1:0] valid_q;

  op_e    op_q;
  color_t idx_q;
  color_t val_q;
  logic   eob_q;
  color_t map_rd_q;
  count_t cnt_rd_q;

  logic   out_valid_q;
  kind_e  kind_q;
  color_t pix_q;
  count_t cnt_q;
  logic   last_q;

  count_t cur_cnt;
  count_t inc_cnt;
  logic   do_remap;
  logic   do_read;

  // beat payload, captured with both memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      idx_q    <= color_index_i;
      val_q    <= map_value_i;
      eob_q    <= end_of_block_i;
      map_rd_q <= color_map_mem[color_index_i];
      cnt_rd_q <= color_counts_mem[color_index_i];
    end
  end

  assign do_remap = cmd_i.execute && (op_q == OP_REMAP);
  assign do_read  = cmd_i.execute && (op_q == OP_READ);

  always_comb begin
    cur_cnt = valid_q[idx_q] ? cnt_rd_q : '0;
    inc_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && (op_q == OP_LOAD)) begin
      color_map_mem[idx_q] <= val_q;
    end
    if (do_remap) begin
      color_counts_mem[idx_q] <= inc_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.execute && (op_q == OP_CLEAR)) begin
      valid_q <= '0;
    end else if (do_remap) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_remap || do_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_remap) begin
      kind_q <= KIND_PIXEL;
      pix_q  <= map_rd_q;
      cnt_q  <= '0;
      last_q <= eob_q;
    end else if (do_read) begin
      kind_q <= KIND_COUNT;
      pix_q  <= '0;
      cnt_q  <= cur_cnt;
      last_q <= 1'b0;
    end
  end

  assign sts_o.has_result = (op_q == OP_REMAP) || (op_q == OP_READ);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign mapped_pixel_o = pix_q;
  assign count_value_o  = cnt_q;
  assign end_last_o     = last_q;

  a_clear_drops_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (op_q == OP_CLEAR) |=> (valid_q == '0))
    else $error("valid bits survive a clear");

  a_remap_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_remap |=> valid_q[$past(idx_q)])
    else $error("remap left its counter invalid");

  a_invalid_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read && !valid_q[idx_q] |=> (out_valid_q && (cnt_q == '0)))
    else $error("invalid counter read is not zero");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_remap || do_read) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule
